### src/itoa_pkg.sv
// Shared types, constants and helpers for the radix text converter.
// No dependencies; used by every module of the block.
package itoa_pkg;

  // Operand width and derived sizes
  localparam int VALUE_WIDTH = 32;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int ADDR_W      = $clog2(VALUE_WIDTH);
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int STEP_W      = $clog2(VALUE_WIDTH);

  // Radix limits, reset value and fixed characters
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(35);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  MINUS_CHAR  = CHAR_W'(8'h2D);
  localparam logic [CHAR_W-1:0]  ZERO_CHAR   = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0]  ALPHA_CHAR  = CHAR_W'(8'h61);
  localparam logic [CHAR_W-1:0]  EMPTY_CHAR  = '0;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } state_t;

  // Divider result bundle
  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [RADIX_W-1:0]     remainder;
  } div_res_t;

  // Map a digit value to its lowercase ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < RADIX_W'(10)) begin
      digit_char = ZERO_CHAR + dx;
    end else begin
      digit_char = ALPHA_CHAR + dx - CHAR_W'(10);
    end
  endfunction

endpackage

### src/itoa_div.sv
// Restoring divider: one quotient bit per cycle.
// Depends on itoa_pkg.
module itoa_div (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   div_go,
  input  logic [itoa_pkg::VALUE_WIDTH-1:0]       dividend,
  input  logic [itoa_pkg::RADIX_W-1:0]           divisor,
  output itoa_pkg::div_res_t                     res
);

  logic [itoa_pkg::VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [itoa_pkg::RADIX_W-1:0]     rem_r, rem_nxt;
  logic [itoa_pkg::RADIX_W-1:0]     dvs_r;
  logic [itoa_pkg::STEP_W-1:0]      step_r;
  logic                             run_r, done_r;
  logic [itoa_pkg::RADIX_W:0]       trial;
  logic                             ge;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, q_r[itoa_pkg::VALUE_WIDTH-1]};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? itoa_pkg::RADIX_W'(trial - {1'b0, dvs_r})
                 : trial[itoa_pkg::RADIX_W-1:0];
    q_nxt   = {q_r[itoa_pkg::VALUE_WIDTH-2:0], ge};
  end

  // Control: load on go, run a fixed number of steps, pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (div_go) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == itoa_pkg::STEP_W'(itoa_pkg::VALUE_WIDTH - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: operands and partial results
  always_ff @(posedge clk) begin
    if (div_go) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign res.done      = done_r;
  assign res.quotient  = q_r;
  assign res.remainder = rem_r;

endmodule

### src/int_to_ascii_radix.sv
// Signed integer to ASCII text in a programmable radix; uses itoa_pkg and itoa_div.
// Sequence: divide repeatedly by the radix, storing one digit per pass, then emit
//   an optional minus sign and read the digits back, most significant first.
// Throughput: one word at a time, busy throughout, set by the shared bit-serial
//   divider; an invalid radix gives one result on the next cycle without busy.
// Reset (synchronous, rst_n low): radix 10, sequencer idle, no strobe; no stalls.
module int_to_ascii_radix (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [itoa_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                                    out_strobe,
  output logic [itoa_pkg::CHAR_W-1:0]             out_character,
  output logic                                    out_last,
  output logic                                    out_empty_res,
  input  logic                                    cfg_we,
  input  logic [itoa_pkg::RADIX_W-1:0]            cfg_data
);

  itoa_pkg::state_t                 state_r, state_nxt;
  logic [itoa_pkg::RADIX_W-1:0]     radix_r;
  logic [itoa_pkg::VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic                             neg_r, neg_nxt;
  logic [itoa_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             strobe_r, strobe_nxt;
  logic [itoa_pkg::CHAR_W-1:0]      char_r, char_nxt;
  logic                             last_r, last_nxt;
  logic                             empty_r, empty_nxt;
  logic                             div_go, mem_we;
  logic                             radix_ok;
  logic [itoa_pkg::VALUE_WIDTH-1:0] in_u;
  logic [itoa_pkg::ADDR_W-1:0]      rd_addr;
  logic [itoa_pkg::RADIX_W-1:0]     rd_data_r;
  logic [itoa_pkg::RADIX_W-1:0]     digit_mem [itoa_pkg::VALUE_WIDTH];
  itoa_pkg::div_res_t               div_res;

  assign radix_ok = (radix_r >= itoa_pkg::RADIX_MIN) && (radix_r <= itoa_pkg::RADIX_MAX);
  assign in_u     = in_value;
  assign rd_addr  = itoa_pkg::ADDR_W'(cnt_r - 1'b1);
  assign busy     = (state_r != itoa_pkg::ST_IDLE);

  // Shared divider
  itoa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .div_go   (div_go),
    .dividend (mag_r),
    .divisor  (radix_r),
    .res      (div_res)
  );

  // Digit store: written as digits come out, read back in reverse
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[cnt_r[itoa_pkg::ADDR_W-1:0]] <= div_res.remainder;
    end
    rd_data_r <= digit_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (start && radix_ok) state_nxt = itoa_pkg::ST_DIV_GO;
      end
      itoa_pkg::ST_DIV_GO: state_nxt = itoa_pkg::ST_DIV_WAIT;
      itoa_pkg::ST_DIV_WAIT: begin
        if (div_res.done) begin
          if (div_res.quotient != '0) begin
            state_nxt = itoa_pkg::ST_DIV_GO;
          end else if (neg_r) begin
            state_nxt = itoa_pkg::ST_SIGN;
          end else begin
            state_nxt = itoa_pkg::ST_READ;
          end
        end
      end
      itoa_pkg::ST_SIGN: state_nxt = itoa_pkg::ST_READ;
      itoa_pkg::ST_READ: state_nxt = itoa_pkg::ST_EMIT;
      itoa_pkg::ST_EMIT: begin
        state_nxt = (cnt_r == itoa_pkg::CNT_W'(1)) ? itoa_pkg::ST_IDLE : itoa_pkg::ST_READ;
      end
      default: state_nxt = itoa_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    div_go     = 1'b0;
    mem_we     = 1'b0;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    strobe_nxt = 1'b0;
    char_nxt   = char_r;
    last_nxt   = last_r;
    empty_nxt  = empty_r;
    case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (start) begin
          if (radix_ok) begin
            neg_nxt = in_u[itoa_pkg::VALUE_WIDTH-1];
            mag_nxt = in_u[itoa_pkg::VALUE_WIDTH-1] ? (~in_u + 1'b1) : in_u;
            cnt_nxt = '0;
          end else begin
            strobe_nxt = 1'b1;
            char_nxt   = itoa_pkg::EMPTY_CHAR;
            last_nxt   = 1'b1;
            empty_nxt  = 1'b1;
          end
        end
      end
      itoa_pkg::ST_DIV_GO: div_go = 1'b1;
      itoa_pkg::ST_DIV_WAIT: begin
        // store the digit, keep the quotient for the next pass
        if (div_res.done) begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          mag_nxt = div_res.quotient;
        end
      end
      itoa_pkg::ST_SIGN: begin
        strobe_nxt = 1'b1;
        char_nxt   = itoa_pkg::MINUS_CHAR;
        last_nxt   = 1'b0;
        empty_nxt  = 1'b0;
      end
      itoa_pkg::ST_READ: begin
      end
      itoa_pkg::ST_EMIT: begin
        strobe_nxt = 1'b1;
        char_nxt   = itoa_pkg::digit_char(rd_data_r);
        last_nxt   = (cnt_r == itoa_pkg::CNT_W'(1));
        empty_nxt  = 1'b0;
        cnt_nxt    = cnt_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= itoa_pkg::ST_IDLE;
      radix_r  <= itoa_pkg::RADIX_RESET;
      strobe_r <= 1'b0;
      cnt_r    <= '0;
      neg_r    <= 1'b0;
      mag_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      cnt_r    <= cnt_nxt;
      neg_r    <= neg_nxt;
      mag_r    <= mag_nxt;
      if (cfg_we) radix_r <= cfg_data;
    end
  end

  // Result word registers
  always_ff @(posedge clk) begin
    char_r  <= char_nxt;
    last_r  <= last_nxt;
    empty_r <= empty_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_character = char_r;
  assign out_last      = last_r;
  assign out_empty_res = empty_r;

endmodule

### src/itoa_chk.sv
// Port-level checker for int_to_ascii_radix, bound to the top level.
// Depends on itoa_pkg and int_to_ascii_radix.
module itoa_chk (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    busy,
  input logic                                    out_strobe,
  input logic [itoa_pkg::CHAR_W-1:0]             out_character,
  input logic                                    out_last,
  input logic                                    out_empty_res
);

  // Reset leaves the block idle with no word on the output
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_strobe && !busy))
    else $error("word or busy right after reset");

  // An empty word is a lone, final, zero character
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_empty_res) |-> (out_last && out_character == itoa_pkg::EMPTY_CHAR))
    else $error("malformed empty word");

  // A sign never ends the text
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_character == itoa_pkg::MINUS_CHAR) |-> !out_last)
    else $error("minus sign marked last");

  // More characters pending keeps the block busy
  a_busy_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |-> busy)
    else $error("idle with text still pending");

  // The final character frees the block
  a_idle_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> !busy)
    else $error("still busy at final character");

endmodule

bind int_to_ascii_radix itoa_chk u_itoa_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_character (out_character),
  .out_last      (out_last),
  .out_empty_res (out_empty_res)
);
